// ----- rtl/rsd_pkg.sv -----
// Package for the minimal standard random draw unit.
// Holds widths, LCG constants, the control state type and the divider link structs.
// No dependencies.
package rsd_pkg;

    // Field widths
    localparam int SeedW  = 31;
    localparam int RangeW = 31;

    // Park-Miller constants: modulus 2^31-1, multiplier 16807 (15 bits)
    localparam int                MultW      = 15;
    localparam logic [SeedW-1:0]  LcgModulus = 31'h7FFF_FFFF;
    localparam logic [MultW-1:0]  LcgMult    = 15'd16807;

    // Iteration counts
    localparam int MultSteps = MultW;
    localparam int DivSteps  = SeedW;
    localparam int MultIdxW  = $clog2(MultSteps);
    localparam int DivCntW   = $clog2(DivSteps);

    // Opcodes carried on the input tuser bit
    localparam logic OP_DRAW = 1'b0;
    localparam logic OP_SEED = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MULT,
        ST_DIV,
        ST_DONE
    } rsd_state_t;

    // Divider control and status
    typedef struct packed {
        logic start;
    } rsd_div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } rsd_div_stat_t;

endpackage

// ----- rtl/minimal_standard_random_draw_unit.sv -----
// Top level of the minimal standard random draw unit (Park-Miller LCG, 16807 mod 2^31-1).
// Depends on rsd_pkg and rsd_divider.
//
// Channel  Dir  Width         Contents
// s_*      in   tdata 64      new_seed / range_limit, tuser = opcode
// m_*      out  tdata 32      random_value, tuser = range_error
//
// A seed transfer only loads the seed register. A draw runs bit-serial
// modular multiplication (one multiplier bit per cycle, Mersenne doubling by
// rotation), then the remainder unit (31 steps, then its done flag is seen),
// then loads the output register; only after that is the next item taken.
// A zero range skips the remainder unit. s_tready is high only between items.
// A finished result waits in the output register while the next item is taken;
// a draw whose result finds that register still full waits in its last state.
// Reset clears the seed to 1 and empties the output register.
module minimal_standard_random_draw_unit
    import rsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [30:0] range_limit, [61:31] new_seed, [63:62] zero
    input  logic        s_tuser,   // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [30:0] random_value, [31] zero
    output logic        m_tuser    // [0] range_error
);

    rsd_state_t          state_reg, state_next;
    logic [SeedW-1:0]    seed_reg,  seed_next;
    logic [SeedW-1:0]    src_reg,   src_next;
    logic [SeedW-1:0]    acc_reg,   acc_next;
    logic [MultIdxW-1:0] idx_reg,   idx_next;
    logic [RangeW-1:0]   range_reg, range_next;
    logic                mv_reg,    mv_next;
    logic [RangeW-1:0]   mval_reg,  mval_next;
    logic                merr_reg,  merr_next;

    logic                in_xfer;
    logic                range_zero;
    logic                mult_last;
    logic                out_load;
    logic [SeedW-1:0]    acc_dbl;
    logic [SeedW:0]      acc_sum;
    logic [SeedW:0]      acc_red;
    logic [SeedW-1:0]    acc_step;
    logic [RangeW-1:0]   in_range;
    logic [SeedW-1:0]    in_seed;
    logic [RangeW-1:0]   div_rem;
    rsd_div_ctl_t        div_ctl;
    rsd_div_stat_t       div_stat;

    assign in_range   = s_tdata[RangeW-1:0];
    assign in_seed    = s_tdata[RangeW+SeedW-1:RangeW];
    assign in_xfer    = s_tvalid && s_tready;
    assign range_zero = (range_reg == '0);
    assign mult_last  = (idx_reg == '0);

    // Next-state logic
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_xfer && (s_tuser == OP_DRAW))
                    state_next = ST_MULT;
            ST_MULT:
                if (mult_last)
                    state_next = range_zero ? ST_DONE : ST_DIV;
            ST_DIV:
                if (div_stat.done)
                    state_next = ST_DONE;
            ST_DONE:
                if (!mv_reg || m_tready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        s_tready      = 1'b0;
        out_load      = 1'b0;
        div_ctl.start = 1'b0;
        case (state_reg)
            ST_IDLE: s_tready      = 1'b1;
            ST_MULT: div_ctl.start = mult_last && !range_zero;
            ST_DIV:  ;
            ST_DONE: out_load      = !mv_reg || m_tready;
            default: ;
        endcase
    end

    // One multiplier bit per cycle: acc = 2*acc (+ src) mod 2^31-1
    always_comb
    begin
        acc_dbl  = {acc_reg[SeedW-2:0], acc_reg[SeedW-1]};
        acc_sum  = {1'b0, acc_dbl} + (LcgMult[idx_reg] ? {1'b0, src_reg} : '0);
        acc_red  = acc_sum - {1'b0, LcgModulus};
        acc_step = (acc_sum >= {1'b0, LcgModulus}) ? acc_red[SeedW-1:0]
                                                   : acc_sum[SeedW-1:0];
    end

    // Seed, multiplier and operand registers
    always_comb
    begin
        seed_next  = seed_reg;
        src_next   = src_reg;
        acc_next   = acc_reg;
        idx_next   = idx_reg;
        range_next = range_reg;

        if (in_xfer)
        begin
            if (s_tuser == OP_SEED)
                seed_next = in_seed;
            else
            begin
                // zero seed is replaced by one before the update
                src_next   = (seed_reg == '0) ? SeedW'(1) : seed_reg;
                acc_next   = '0;
                idx_next   = MultIdxW'(MultSteps - 1);
                range_next = in_range;
            end
        end
        else if (state_reg == ST_MULT)
        begin
            acc_next = acc_step;
            idx_next = idx_reg - 1'b1;
            if (mult_last)
                seed_next = acc_step;
        end
    end

    // Output register
    always_comb
    begin
        mv_next   = mv_reg;
        mval_next = mval_reg;
        merr_next = merr_reg;
        if (out_load)
        begin
            mv_next   = 1'b1;
            mval_next = range_zero ? '0 : div_rem;
            merr_next = range_zero;
        end
        else if (m_tready)
            mv_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            seed_reg  <= SeedW'(1);
            idx_reg   <= '0;
            mv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            seed_reg  <= seed_next;
            idx_reg   <= idx_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg   <= src_next;
        acc_reg   <= acc_next;
        range_reg <= range_next;
        mval_reg  <= mval_next;
        merr_reg  <= merr_next;
    end

    // Remainder of the new seed by the range; the divider loads on the last
    // multiplier step, where acc_step is the new seed
    rsd_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (div_ctl),
        .dividend  (acc_step),
        .divisor   (range_reg),
        .stat      (div_stat),
        .remainder (div_rem)
    );

    assign m_tvalid = mv_reg;
    assign m_tdata  = {1'b0, mval_reg};
    assign m_tuser  = merr_reg;

endmodule

// ----- rtl/rsd_divider.sv -----
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// Depends on rsd_pkg.
module rsd_divider
    import rsd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  rsd_div_ctl_t        ctl,
    input  logic [SeedW-1:0]    dividend,
    input  logic [RangeW-1:0]   divisor,
    output rsd_div_stat_t       stat,
    output logic [RangeW-1:0]   remainder
);

    logic [SeedW-1:0]   dvd_reg,  dvd_next;
    logic [RangeW-1:0]  dsr_reg,  dsr_next;
    logic [RangeW-1:0]  rem_reg,  rem_next;
    logic [DivCntW-1:0] cnt_reg,  cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;

    logic [RangeW:0]    trial;
    logic [RangeW:0]    diff;
    logic               last_step;

    // One trial subtraction per cycle
    always_comb
    begin
        trial     = {rem_reg, dvd_reg[SeedW-1]};
        diff      = trial - {1'b0, dsr_reg};
        last_step = (cnt_reg == DivCntW'(DivSteps - 1));

        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (ctl.start)
        begin
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so it fits in RangeW bits
            if (trial >= {1'b0, dsr_reg})
                rem_next = diff[RangeW-1:0];
            else
                rem_next = trial[RangeW-1:0];
            dvd_next = {dvd_reg[SeedW-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (last_step)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign remainder = rem_reg;

endmodule

// ----- rtl/rsd_checker.sv -----
// Port-level checks for the minimal standard random draw unit, bound to the top level.
// Depends on minimal_standard_random_draw_unit.
module rsd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [63:0] s_tdata,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser
);

    // A stalled result stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // A range error always carries a zero value
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (m_tdata == 32'd0))
        else $error("range error with non-zero value");

    // A seed transfer never produces a result
    a_seed_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser && !m_tvalid |=> !m_tvalid)
        else $error("seed transfer produced a result");

    // After a draw transfer the unit is busy
    a_draw_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tuser |=> !s_tready)
        else $error("new transfer taken during a draw");

endmodule

bind minimal_standard_random_draw_unit rsd_checker u_rsd_checker (.*);

// ----- tb/minimal_standard_random_draw_unit_tb.sv -----
// Testbench for minimal_standard_random_draw_unit: directed table, then random draws and seed loads.
// The Park-Miller sequence is predicted here and each result is checked in order.
// Depends on rsd_pkg and the RTL of the unit.
`timescale 1ns / 100ps

module minimal_standard_random_draw_unit_tb
    import rsd_pkg::*;
();

    localparam logic [30:0] MaxVal     = 31'h7FFF_FFFF;
    localparam int          NumRandom  = 950;
    localparam int          NumChunks  = 8;
    localparam int          DrainWait  = 60;
    localparam int          StallLimit = 2000;

    typedef struct packed {
        logic [30:0] value;
        logic        range_err;
    } draw_result_t;

    // One row of the directed table; fixed marks an expectation typed in by hand
    typedef struct packed {
        logic         op;
        logic [30:0]  range_limit;
        logic [30:0]  new_seed;
        bit           fixed;
        draw_result_t want;
    } stim_row_t;

    localparam draw_result_t NoWant = '{value: 31'd0, range_err: 1'b0};

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // [30:0] range_limit, [61:31] new_seed, [63:62] zero
    logic        s_tuser;   // [0] opcode
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [30:0] random_value, [31] zero
    logic        m_tuser;   // [0] range_error

    // Predictor state and pending draws
    logic [30:0]  lcg_seed;
    draw_result_t pending_draws[$];
    int           fail_count = 0;
    int           quiet_cycles = 0;
    int           src_idle_pct;
    int           sink_stall_pct;

    stim_row_t directed_rows [20] = '{
        // straight after reset: seed 1 steps to 16807
        '{OP_DRAW, MaxVal,          31'd0,          1'b1, '{31'd16807, 1'b0}},
        // zero range flags an error
        '{OP_DRAW, 31'd0,           MaxVal,         1'b1, '{31'd0, 1'b1}},
        '{OP_DRAW, 31'd1,           31'd0,          1'b1, '{31'd0, 1'b0}},
        // zero seed is replaced by one before the step
        '{OP_SEED, 31'h5555_5555,   31'd0,          1'b0, NoWant},
        '{OP_DRAW, MaxVal,          31'h2AAA_AAAA,  1'b1, '{31'd16807, 1'b0}},
        // seed equal to the modulus steps to zero, then back to one
        '{OP_SEED, MaxVal,          MaxVal,         1'b0, NoWant},
        '{OP_DRAW, 31'd5,           31'd0,          1'b1, '{31'd0, 1'b0}},
        '{OP_DRAW, MaxVal,          MaxVal,         1'b1, '{31'd16807, 1'b0}},
        '{OP_SEED, MaxVal,          31'd1,          1'b0, NoWant},
        '{OP_DRAW, 31'h7FFF_FFFE,   31'd0,          1'b0, NoWant},
        '{OP_DRAW, 31'd2,           31'h5555_5555,  1'b0, NoWant},
        '{OP_SEED, 31'd0,           31'h2AAA_AAAA,  1'b0, NoWant},
        '{OP_DRAW, 31'h5555_5555,   31'd0,          1'b0, NoWant},
        '{OP_SEED, 31'h2AAA_AAAA,   31'h5555_5555,  1'b0, NoWant},
        '{OP_DRAW, 31'h2AAA_AAAA,   31'd0,          1'b0, NoWant},
        '{OP_DRAW, 31'h4000_0000,   31'd0,          1'b0, NoWant},
        '{OP_SEED, 31'd0,           31'h7FFF_FFFE,  1'b0, NoWant},
        '{OP_DRAW, MaxVal,          31'd0,          1'b0, NoWant},
        '{OP_DRAW, 31'd0,           31'd0,          1'b1, '{31'd0, 1'b1}},
        '{OP_DRAW, 31'd3,           MaxVal,         1'b0, NoWant}
    };

    minimal_standard_random_draw_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #6 clk = ~clk;

    // Steps the seed and works out the drawn number
    function automatic draw_result_t predict_draw(input logic [30:0] range_limit);
        longint unsigned product;
        draw_result_t    res;
        if (lcg_seed == 31'd0)
            lcg_seed = 31'd1;
        product  = 64'(lcg_seed) * 64'(LcgMult);
        lcg_seed = 31'(product % 64'(LcgModulus));
        if (range_limit == 31'd0)
            res = '{value: 31'd0, range_err: 1'b1};
        else
            res = '{value: lcg_seed % range_limit, range_err: 1'b0};
        return res;
    endfunction

    // Offers one item, holds it until the transfer, then updates the prediction
    task automatic offer_item(input logic op, input logic [30:0] range_limit,
                              input logic [30:0] new_seed, input bit fixed,
                              input draw_result_t want);
        draw_result_t res;
        if ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, new_seed, range_limit};
        s_tuser  <= op;
        do @(posedge clk); while (!s_tready);
        if (op == OP_SEED)
            lcg_seed = new_seed;
        else
        begin
            res = predict_draw(range_limit);
            pending_draws.push_back(fixed ? want : res);
        end
    endtask

    task automatic set_pressure(input int mode);
        case (mode)
            0:
            begin
                src_idle_pct   = 0;
                sink_stall_pct = 0;
            end
            1:
            begin
                src_idle_pct   = 80;
                sink_stall_pct = 0;
            end
            2:
            begin
                src_idle_pct   = 0;
                sink_stall_pct = 80;
            end
            default:
            begin
                src_idle_pct   = 19;
                sink_stall_pct = 19;
            end
        endcase
    endtask

    // Sink side: random back-pressure
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= sink_stall_pct);

    // Result check and watchdog
    always @(posedge clk)
    begin
        draw_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_draws.size() == 0)
            begin
                $error("unexpected result: random_value %0d, range_error %0b",
                       m_tdata[30:0], m_tuser);
                fail_count++;
            end
            else
            begin
                want = pending_draws.pop_front();
                if (m_tdata[30:0] !== want.value)
                begin
                    $error("random_value: expected %0d, got %0d", want.value, m_tdata[30:0]);
                    fail_count++;
                end
                if (m_tuser !== want.range_err)
                begin
                    $error("range_error: expected %0b, got %0b", want.range_err, m_tuser);
                    fail_count++;
                end
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit)
        begin
            $display("minimal_standard_random_draw_unit_tb NOT OK");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        logic        op;
        logic [30:0] range_limit;
        logic [30:0] new_seed;
        int          chunk;
        clk          = 1'b0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = OP_DRAW;
        lcg_seed     = 31'd1;
        set_pressure(0);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        foreach (directed_rows[i])
            offer_item(directed_rows[i].op, directed_rows[i].range_limit,
                       directed_rows[i].new_seed, directed_rows[i].fixed,
                       directed_rows[i].want);

        // Random part, cycling through the back-pressure modes
        for (int n = 0; n < NumRandom; n++)
        begin
            chunk = n * NumChunks / NumRandom;
            set_pressure(chunk % 4);
            op = ($urandom_range(99) < 15) ? OP_SEED : OP_DRAW;
            case ($urandom_range(9))
                0:       new_seed = 31'd0;
                1:       new_seed = MaxVal;
                2:       new_seed = MaxVal - 31'd1;
                default: new_seed = 31'($urandom());
            endcase
            case ($urandom_range(9))
                0:       range_limit = 31'd0;
                1:       range_limit = 31'd1;
                2:       range_limit = MaxVal;
                3, 4:    range_limit = 31'($urandom_range(100, 1));
                5:       range_limit = 31'd1 << $urandom_range(30);
                default: range_limit = 31'($urandom());
            endcase
            offer_item(op, range_limit, new_seed, 1'b0, NoWant);
        end
        s_tvalid <= 1'b0;
        set_pressure(3);

        // Drain, then allow the block's latency before the verdict
        while (pending_draws.size() != 0)
            @(posedge clk);
        repeat (DrainWait) @(posedge clk);
        if (fail_count == 0 && pending_draws.size() == 0)
            $display("minimal_standard_random_draw_unit_tb OK");
        else
            $display("minimal_standard_random_draw_unit_tb NOT OK");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/rsd_pkg.sv
rtl/rsd_divider.sv
rtl/minimal_standard_random_draw_unit.sv
rtl/rsd_checker.sv
tb/minimal_standard_random_draw_unit_tb.sv
